>>> src/bwi_pkg.sv
// ----------------------------------------------------------------------------
// Bicubic window interpolator package
// Widths, pipeline depth and default settings shared by the interpolator
// modules.
// ----------------------------------------------------------------------------
package bwi_pkg;

  // Item field widths.
  localparam int PIX_W  = 8;
  localparam int ROW_W  = 4 * PIX_W;
  localparam int FRAC_W = 16;

  // Default number of fraction bits in frac_x and frac_y.
  localparam int DEF_FRAC_BITS = 16;

  // A pixel as a signed sample, and the widths of the two kernel results.
  // Each kernel pass grows the sample magnitude by less than a factor of 16.
  localparam int PIX_SW = PIX_W + 1;
  localparam int ROWV_W = PIX_SW + 4;
  localparam int COLV_W = ROWV_W + 4;

  // Register stages in one cubic kernel pass.
  localparam int CUBIC_LAT = 7;

  // Upper end of the output byte range.
  localparam int PIX_MAX = 255;

endpackage

>>> src/bwi_cubic.sv
// ----------------------------------------------------------------------------
// Cubic kernel pass
// Seven-stage pipeline for one Catmull-Rom kernel evaluation over four signed
// samples, with exact add-one-half and truncate-toward-zero rounding at each
// of the three products.
// ----------------------------------------------------------------------------
module bwi_cubic #(
  parameter int AW        = bwi_pkg::PIX_SW,
  parameter int FRAC_BITS = bwi_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_vld,
  input  logic [bwi_pkg::FRAC_W-1:0]  t,
  input  logic signed [AW-1:0]        a0,
  input  logic signed [AW-1:0]        a1,
  input  logic signed [AW-1:0]        a2,
  input  logic signed [AW-1:0]        a3,
  output logic                        out_vld,
  output logic signed [AW+3:0]        k
);
  import bwi_pkg::*;

  // Term widths, sized from the worst case magnitude of the samples.
  localparam int TW  = FRAC_W + 1;
  localparam int C3W = AW + 3;
  localparam int C2W = AW + 4;
  localparam int MW  = AW + 5;
  localparam int SW  = AW + 5;
  localparam int OW  = AW + 4;
  localparam int P3W = TW + C3W;
  localparam int P2W = TW + MW;
  localparam int P1W = TW + SW;
  localparam int NW  = (AW + FRAC_BITS + 2 > P1W) ? AW + FRAC_BITS + 2 : P1W;
  localparam int RW  = NW + 2;

  // Adds one half and truncates toward zero after dropping sh fraction bits.
  function automatic logic signed [RW-1:0] rnd_half(input logic signed [RW-1:0] x,
                                                      input int sh);
    logic signed [RW-1:0] one;
    logic signed [RW-1:0] q;
    one = RW'(1);
    q   = x + (one <<< (sh - 1));
    if (q < 0) begin
      return (q + (one <<< sh) - one) >>> sh;
    end else begin
      return q >>> sh;
    end
  endfunction

  // Pipeline registers.
  logic                  v1, v2, v3, v4, v5, v6, v7;
  logic signed [TW-1:0]  t1, t2, t3, t4, t5;
  logic signed [AW-1:0]  a0_1, a0_2, a0_3, a0_4;
  logic signed [AW-1:0]  a1_1, a1_2, a1_3, a1_4, a1_5, a1_6;
  logic signed [AW-1:0]  a2_1, a2_2, a2_3, a2_4;
  logic signed [C3W-1:0] c3_1;
  logic signed [C2W-1:0] c2_1, c2_2;
  logic signed [P3W-1:0] p3_2;
  logic signed [MW-1:0]  m2_3;
  logic signed [P2W-1:0] p2_4;
  logic signed [SW-1:0]  s_5;
  logic signed [P1W-1:0] p1_6;
  logic signed [OW-1:0]  k_7;

  // Next values of the stages that round.
  logic signed [C3W-1:0] c3_next;
  logic signed [C2W-1:0] c2_next;
  logic signed [RW-1:0]  r3_full;
  logic signed [MW-1:0]  m2_next;
  logic signed [RW-1:0]  r2_full;
  logic signed [SW-1:0]  s_next;
  logic signed [RW-1:0]  num_full;
  logic signed [RW-1:0]  k_full;
  logic signed [OW-1:0]  k_next;

  // Polynomial coefficients of the cubic and quadratic terms.
  always_comb begin
    c3_next = C3W'(a3 - a0) + C3W'(3 * (C3W'(a1) - C3W'(a2)));
    c2_next = C2W'(2 * C2W'(a0)) - C2W'(5 * C2W'(a1)) + C2W'(4 * C2W'(a2)) - C2W'(a3);
  end

  // Rounded cubic term folded into the quadratic coefficient.
  always_comb begin
    r3_full = rnd_half(RW'(p3_2), FRAC_BITS);
    m2_next = MW'(RW'(c2_2) + r3_full);
  end

  // Rounded quadratic term folded into the linear coefficient.
  always_comb begin
    r2_full = rnd_half(RW'(p2_4), FRAC_BITS);
    s_next  = SW'(RW'(a2_4) - RW'(a0_4) + r2_full);
  end

  // Final sum over one extra bit, which halves the whole expression.
  always_comb begin
    num_full = (RW'(a1_6) <<< (FRAC_BITS + 1)) + RW'(p1_6);
    k_full   = rnd_half(num_full, FRAC_BITS + 1);
    k_next   = OW'(k_full);
  end

  // Valid bits travel with the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  // Datapath stages: coefficients, three multiply and round steps.
  always_ff @(posedge clk) begin
    t1   <= TW'($signed({1'b0, t}));
    a0_1 <= a0;
    a1_1 <= a1;
    a2_1 <= a2;
    c3_1 <= c3_next;
    c2_1 <= c2_next;

    t2   <= t1;
    a0_2 <= a0_1;
    a1_2 <= a1_1;
    a2_2 <= a2_1;
    c2_2 <= c2_1;
    p3_2 <= P3W'(t1) * P3W'(c3_1);

    t3   <= t2;
    a0_3 <= a0_2;
    a1_3 <= a1_2;
    a2_3 <= a2_2;
    m2_3 <= m2_next;

    t4   <= t3;
    a0_4 <= a0_3;
    a1_4 <= a1_3;
    a2_4 <= a2_3;
    p2_4 <= P2W'(t3) * P2W'(m2_3);

    t5   <= t4;
    a1_5 <= a1_4;
    s_5  <= s_next;

    a1_6 <= a1_5;
    p1_6 <= P1W'(t5) * P1W'(s_5);

    k_7  <= k_next;
  end

  assign out_vld = v7;
  assign k       = k_7;

endmodule

>>> src/bicubic_window_interpolator.sv
// ----------------------------------------------------------------------------
// Bicubic window interpolator
// Catmull-Rom interpolation of a 4x4 pixel window at a fractional position,
// clamped to a byte.
// ----------------------------------------------------------------------------
// The block takes one item per clock and never holds one off: busy stays low.
// Each item gives one pixel on pixel_out, marked by done, after passing
// through seven stages for the four row kernels running side by side,
// seven for the column kernel over the row results, and one for the clamp
// into the output register. Each kernel has three multiplies, each in a stage
// of its own, and that sets the depth. Only the low FRAC_BITS bits of frac_x
// and frac_y are used when FRAC_BITS is below 16.
module bicubic_window_interpolator #(
  parameter int FRAC_BITS = bwi_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [bwi_pkg::ROW_W-1:0]   row_top,
  input  logic [bwi_pkg::ROW_W-1:0]   row_upper,
  input  logic [bwi_pkg::ROW_W-1:0]   row_lower,
  input  logic [bwi_pkg::ROW_W-1:0]   row_bottom,
  input  logic [bwi_pkg::FRAC_W-1:0]  frac_x,
  input  logic [bwi_pkg::FRAC_W-1:0]  frac_y,
  output logic                        done,
  output logic [bwi_pkg::PIX_W-1:0]   pixel_out
);
  import bwi_pkg::*;

  localparam logic [FRAC_W-1:0] FRAC_MASK =
    (FRAC_BITS >= FRAC_W) ? {FRAC_W{1'b1}} : FRAC_W'((1 << FRAC_BITS) - 1);
  localparam int LAT = 2 * CUBIC_LAT + 1;
  localparam logic signed [COLV_W-1:0] PIX_MAX_S = COLV_W'(PIX_MAX);

  logic                     accept;
  logic [FRAC_W-1:0]        tx;
  logic [FRAC_W-1:0]        ty;
  logic [ROW_W-1:0]         rows [4];
  logic [3:0]               row_vld;
  logic signed [ROWV_W-1:0] row_val [4];
  logic [FRAC_W-1:0]        ty_pipe [CUBIC_LAT];
  logic                     col_vld;
  logic signed [COLV_W-1:0] col_val;
  logic [PIX_W-1:0]         pixel_next;

  // The pipeline never stalls, so every start is taken.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign tx = frac_x & FRAC_MASK;
  assign ty = frac_y & FRAC_MASK;

  assign rows[0] = row_top;
  assign rows[1] = row_upper;
  assign rows[2] = row_lower;
  assign rows[3] = row_bottom;

  // Horizontal pass: one kernel per window row.
  for (genvar r = 0; r < 4; r++) begin : g_row
    bwi_cubic #(
      .AW        (PIX_SW),
      .FRAC_BITS (FRAC_BITS)
    ) u_row (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (accept),
      .t       (tx),
      .a0      ($signed({1'b0, rows[r][0*PIX_W +: PIX_W]})),
      .a1      ($signed({1'b0, rows[r][1*PIX_W +: PIX_W]})),
      .a2      ($signed({1'b0, rows[r][2*PIX_W +: PIX_W]})),
      .a3      ($signed({1'b0, rows[r][3*PIX_W +: PIX_W]})),
      .out_vld (row_vld[r]),
      .k       (row_val[r])
    );
  end

  // The y fraction waits alongside the row kernels.
  always_ff @(posedge clk) begin
    ty_pipe[0] <= ty;
    for (int i = 1; i < CUBIC_LAT; i++) begin
      ty_pipe[i] <= ty_pipe[i-1];
    end
  end

  // Vertical pass over the four unclamped row results.
  bwi_cubic #(
    .AW        (ROWV_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_col (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (row_vld[0]),
    .t       (ty_pipe[CUBIC_LAT-1]),
    .a0      (row_val[0]),
    .a1      (row_val[1]),
    .a2      (row_val[2]),
    .a3      (row_val[3]),
    .out_vld (col_vld),
    .k       (col_val)
  );

  // Clamp to the byte range.
  always_comb begin
    priority if (col_val < 0) begin
      pixel_next = '0;
    end else if (col_val > PIX_MAX_S) begin
      pixel_next = PIX_W'(PIX_MAX);
    end else begin
      pixel_next = col_val[PIX_W-1:0];
    end
  end

  // Output register: the result item shows for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= col_vld;
    end
    pixel_out <= pixel_next;
  end

`ifndef SYNTH
  // Every accepted item comes out on done.
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("accepted item did not produce a result");

  // No result appears without an item accepted at the matching edge.
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result without a matching accepted item");

  // The four row kernels stay in lockstep.
  a_rows_aligned: assert property (@(posedge clk) disable iff (rst)
    row_vld != 4'b0000 |-> row_vld == 4'b1111)
    else $error("row kernels out of step");

  // The column kernel only carries items that came through the rows.
  a_col_source: assert property (@(posedge clk) disable iff (rst)
    col_vld |-> $past(row_vld[0], CUBIC_LAT))
    else $error("column kernel result without row results");
`endif

endmodule
